>>> sv/ucfr_pkg.sv
// ----------------------------------------------------------------------------
// ucfr_pkg
// Shared types and constants of the UART command frame receiver.
// ----------------------------------------------------------------------------
package ucfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [DATA_W-1:0] PERIOD_RESET = 32'd7200;
  localparam logic [DATA_W-1:0] REBOOT_RESET = 32'd3600;

  localparam logic [CMD_W-1:0] CMD_TIME     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ON       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OFF      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REBOOT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WAKEUP   = 3'd5;

  localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_T       = 8'h74;
  localparam logic [BYTE_W-1:0] CH_P       = 8'h70;
  localparam logic [BYTE_W-1:0] CH_S       = 8'h73;
  localparam logic [BYTE_W-1:0] CH_C       = 8'h63;
  localparam logic [BYTE_W-1:0] CH_R       = 8'h72;
  localparam logic [BYTE_W-1:0] CH_W       = 8'h77;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
  } frame_t;

  typedef struct packed {
    logic             hit;
    logic [CMD_W-1:0] code;
  } letter_t;

  function automatic letter_t letter_code(input logic [BYTE_W-1:0] b);
    letter_t res;
    res.hit  = 1'b1;
    res.code = CMD_TIME;
    unique case (b)
      CH_T:    res.code = CMD_TIME;
      CH_P:    res.code = CMD_ON;
      CH_S:    res.code = CMD_OFF;
      CH_C:    res.code = CMD_RESERVED;
      CH_R:    res.code = CMD_REBOOT;
      CH_W:    res.code = CMD_WAKEUP;
      default: res.hit  = 1'b0;
    endcase
    return res;
  endfunction

endpackage

>>> sv/ucfr_front.sv
// ----------------------------------------------------------------------------
// ucfr_front
// Byte parser: tracks the frame position, gathers the data bytes and pushes
// one frame beat into the queue on a good terminator.
// ----------------------------------------------------------------------------
module ucfr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ucfr_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                        q_full,
  output logic                        q_push,
  output ucfr_pkg::frame_t            q_wdata
);
  import ucfr_pkg::*;

  typedef enum logic [6:0] {
    S_CMD   = 7'b0000001,
    S_COLON = 7'b0000010,
    S_D0    = 7'b0000100,
    S_D1    = 7'b0001000,
    S_D2    = 7'b0010000,
    S_D3    = 7'b0100000,
    S_END   = 7'b1000000
  } pos_t;

  pos_t              pos_r, pos_nxt;
  logic [CMD_W-1:0]  pend_r, pend_nxt;
  logic [DATA_W-1:0] shift_r, shift_nxt;
  logic              accept;
  letter_t           letter;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign letter   = letter_code(in_rx_byte);

  always_comb begin
    pos_nxt   = pos_r;
    pend_nxt  = pend_r;
    shift_nxt = shift_r;
    q_push    = 1'b0;
    if (accept) begin
      unique case (pos_r)
        S_CMD: begin
          if (letter.hit) begin
            pend_nxt = letter.code;
            pos_nxt  = S_COLON;
          end
        end
        S_COLON: begin
          pos_nxt = (in_rx_byte == CH_COLON) ? S_D0 : S_CMD;
        end
        S_D0, S_D1, S_D2, S_D3: begin
          if (in_rx_byte == CH_NEWLINE) begin
            pos_nxt   = S_CMD;
            shift_nxt = '0;
          end else begin
            shift_nxt = {shift_r[DATA_W-BYTE_W-1:0], in_rx_byte};
            pos_nxt   = pos_t'({pos_r[5:0], 1'b0});
          end
        end
        S_END: begin
          pos_nxt = S_CMD;
          if (in_rx_byte == CH_NEWLINE) begin
            q_push = 1'b1;
          end else begin
            shift_nxt = '0;
          end
        end
        default: begin
          pos_nxt   = S_CMD;
          shift_nxt = '0;
        end
      endcase
    end
  end

  assign q_wdata.cmd   = pend_r;
  assign q_wdata.value = shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= S_CMD;
      pend_r  <= CMD_TIME;
      shift_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      pend_r  <= pend_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

>>> sv/ucfr_queue.sv
// ----------------------------------------------------------------------------
// ucfr_queue
// Short frame queue between the parser and the settings stage.
// ----------------------------------------------------------------------------
module ucfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ucfr_pkg::frame_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output ucfr_pkg::frame_t rdata
);
  import ucfr_pkg::*;

  frame_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign valid   = (cnt_r != '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> sv/ucfr_back.sv
// ----------------------------------------------------------------------------
// ucfr_back
// Settings stage: applies each frame to the held settings and presents the
// result beat in an output register.
// ----------------------------------------------------------------------------
module ucfr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  ucfr_pkg::frame_t            q_rdata,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ucfr_pkg::CMD_W-1:0]  out_command,
  output logic [ucfr_pkg::DATA_W-1:0] out_value,
  output logic [ucfr_pkg::DATA_W-1:0] out_on_period_out,
  output logic [ucfr_pkg::DATA_W-1:0] out_off_period_out,
  output logic [ucfr_pkg::DATA_W-1:0] out_reboot_out,
  output logic [ucfr_pkg::DATA_W-1:0] out_wakeup_out
);
  import ucfr_pkg::*;

  logic              vld_r;
  logic [DATA_W-1:0] on_r, on_nxt;
  logic [DATA_W-1:0] off_r, off_nxt;
  logic [DATA_W-1:0] reboot_r, reboot_nxt;
  logic [DATA_W-1:0] wake_r, wake_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] value_r, on_o_r, off_o_r, reboot_o_r, wake_o_r;

  assign q_pop = q_valid && (!vld_r || out_ready);

  always_comb begin
    on_nxt     = on_r;
    off_nxt    = off_r;
    reboot_nxt = reboot_r;
    wake_nxt   = wake_r;
    if (q_pop) begin
      case (q_rdata.cmd)
        CMD_ON:     on_nxt     = q_rdata.value;
        CMD_OFF:    off_nxt    = q_rdata.value;
        CMD_REBOOT: reboot_nxt = q_rdata.value;
        CMD_WAKEUP: wake_nxt   = q_rdata.value;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      on_r     <= PERIOD_RESET;
      off_r    <= PERIOD_RESET;
      reboot_r <= REBOOT_RESET;
      wake_r   <= PERIOD_RESET;
    end else begin
      if (q_pop) begin
        vld_r <= 1'b1;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
      on_r     <= on_nxt;
      off_r    <= off_nxt;
      reboot_r <= reboot_nxt;
      wake_r   <= wake_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r      <= q_rdata.cmd;
      value_r    <= q_rdata.value;
      on_o_r     <= on_nxt;
      off_o_r    <= off_nxt;
      reboot_o_r <= reboot_nxt;
      wake_o_r   <= wake_nxt;
    end
  end

  assign out_valid          = vld_r;
  assign out_command        = cmd_r;
  assign out_value          = value_r;
  assign out_on_period_out  = on_o_r;
  assign out_off_period_out = off_o_r;
  assign out_reboot_out     = reboot_o_r;
  assign out_wakeup_out     = wake_o_r;

endmodule

>>> sv/uart_command_frame_receiver.sv
// ----------------------------------------------------------------------------
// uart_command_frame_receiver
// Recognizes 7-byte command frames in a stream of serial bytes.
// ----------------------------------------------------------------------------
// One received byte is taken per beat, every cycle, and each byte is parsed
// in the cycle it arrives. A frame is a letter (t, p, s, c, r, w), ':', four
// data bytes most significant first and a newline; a complete frame gives
// one result beat with the command code, the 32-bit value and the held
// on-period, off-period, reboot and wakeup settings after the frame. The
// result passes through the two-entry frame queue and then the settings
// stage's output register on its way out. Input is stalled only while the
// queue is full, i.e. when two finished frames are still waiting on a
// stalled result channel.
module uart_command_frame_receiver (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ucfr_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ucfr_pkg::CMD_W-1:0]  out_command,
  output logic [ucfr_pkg::DATA_W-1:0] out_value,
  output logic [ucfr_pkg::DATA_W-1:0] out_on_period_out,
  output logic [ucfr_pkg::DATA_W-1:0] out_off_period_out,
  output logic [ucfr_pkg::DATA_W-1:0] out_reboot_out,
  output logic [ucfr_pkg::DATA_W-1:0] out_wakeup_out
);
  import ucfr_pkg::*;

  logic   q_full, q_push, q_pop, q_valid;
  frame_t q_wdata, q_rdata;

  ucfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  ucfr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  ucfr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command        (out_command),
    .out_value          (out_value),
    .out_on_period_out  (out_on_period_out),
    .out_off_period_out (out_off_period_out),
    .out_reboot_out     (out_reboot_out),
    .out_wakeup_out     (out_wakeup_out)
  );

endmodule
